FILE: design/lcd_4bit_nibble_writer_defines.svh
// assertion macros used by the checker file
`ifndef LCD_4BIT_NIBBLE_WRITER_DEFINES_SVH
`define LCD_4BIT_NIBBLE_WRITER_DEFINES_SVH

// same-cycle implication, reported on failure
`define LNW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reported on failure
`define LNW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lnw_pkg.sv
// shared types, constants and result tables of the lcd nibble writer
package lnw_pkg;

   localparam int unsigned MODE_W   = 2;
   localparam int unsigned WAIT_B_W = 15;
   localparam int unsigned WAIT_A_W = 17;
   localparam int unsigned STEP_W   = 4;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSTR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DATA   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd3;

   // register select levels
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // sequence lengths, as last step index
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;
   localparam logic [STEP_W-1:0] INIT_FIRST_BYTE_STEP = 4'd4;

   // timing in cycles
   localparam logic [WAIT_B_W-1:0] WAIT_POWER_UP  = 15'd20000;
   localparam logic [WAIT_A_W-1:0] WAIT_FIRST_NIB = 17'd10000;
   localparam logic [WAIT_A_W-1:0] WAIT_INIT_NIB  = 17'd1000;
   localparam logic [WAIT_A_W-1:0] WAIT_SETTLE    = 17'd500;
   localparam logic [WAIT_A_W-1:0] WAIT_FINAL     = 17'd100500;

   // cursor address bases
   localparam logic [7:0] ROW0_BASE = 8'h80;
   localparam logic [7:0] ROW1_BASE = 8'hC0;

   // init nibbles and instructions
   localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
   localparam logic [3:0] INIT_NIB_4BIT = 4'h2;
   localparam logic [7:0] INIT_INSTR [4] = '{8'h06, 8'h28, 8'h0C, 8'h01};

   localparam int unsigned LNW_QUEUE_DEPTH = 4;

   // one queued request after classification
   typedef struct packed {
      logic       is_init;
      logic [7:0] byte_val;
      logic       rs;
   } lnw_entry_type;

   // one nibble write
   typedef struct packed {
      logic [3:0]          nibble;
      logic                rs;
      logic [WAIT_B_W-1:0] wait_before;
      logic [WAIT_A_W-1:0] wait_after;
      logic                last;
   } lnw_rsp_type;

   // nibble write of the power-on sequence at a given step
   function automatic lnw_rsp_type init_rsp(logic [STEP_W-1:0] step);
      lnw_rsp_type       r;
      logic [STEP_W-1:0] off;
      logic [7:0]        instr;
      r   = '0;
      off = step - INIT_FIRST_BYTE_STEP;
      instr = INIT_INSTR[off[2:1]];
      r.rs = RS_INSTR;
      if (step < INIT_FIRST_BYTE_STEP) begin
         r.nibble      = (step == 4'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
         r.wait_before = (step == 4'd0) ? WAIT_POWER_UP : '0;
         r.wait_after  = (step == 4'd0) ? WAIT_FIRST_NIB : WAIT_INIT_NIB;
      end else if (off[0]) begin
         r.nibble     = instr[3:0];
         r.wait_after = (step == INIT_LAST_STEP) ? WAIT_FINAL : WAIT_SETTLE;
         r.last       = (step == INIT_LAST_STEP);
      end else begin
         r.nibble = instr[7:4];
      end
      return r;
   endfunction

   // nibble write of a plain byte, high half first
   function automatic lnw_rsp_type byte_rsp(logic [7:0] b, logic rs, logic low_half);
      lnw_rsp_type r;
      r            = '0;
      r.rs         = rs;
      r.nibble     = low_half ? b[3:0] : b[7:4];
      r.wait_after = low_half ? WAIT_SETTLE : '0;
      r.last       = low_half;
      return r;
   endfunction

endpackage

FILE: design/lcd_4bit_nibble_writer.sv
// top level of the 4-bit character lcd nibble writer
//
//   channel   direction  handshake              payload
//   request   in         start && !busy         req_mode req_value req_row req_column
//   result    out        rsp_valid, one cycle   rsp_nibble rsp_reg_select rsp_wait_before
//                                               rsp_wait_after rsp_last
//
// the sequencer emits one nibble write per cycle while a request is queued: two for a
// byte request, twelve for init; with the sequencer idle an accepted request is first
// written into the queue, and its first result then into the result register.
// busy rises only while the request queue (QueueDepth entries) is full.
// reset is synchronous and clears the queue and the sequencer step.
// results cannot be stalled; each is shown for exactly one cycle.
module lcd_4bit_nibble_writer
   import lnw_pkg::*;
#(
   parameter int unsigned QueueDepth = LNW_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [7:0]          req_value,
   input  logic                req_row,
   input  logic [5:0]          req_column,
   output logic                rsp_valid,
   output logic [3:0]          rsp_nibble,
   output logic                rsp_reg_select,
   output logic [WAIT_B_W-1:0] rsp_wait_before,
   output logic [WAIT_A_W-1:0] rsp_wait_after,
   output logic                rsp_last
);

   lnw_entry_type entry;
   lnw_entry_type head;
   lnw_rsp_type   rsp;
   logic          empty;
   logic          full;
   logic          pop;
   logic          push;

   assign busy = full;
   assign push = start && !full;

   // classify request
   lnw_front u_front (
      .req_mode   (req_mode),
      .req_value  (req_value),
      .req_row    (req_row),
      .req_column (req_column),
      .entry      (entry)
   );

   // decoupling queue
   lnw_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   // nibble sequencer
   lnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_nibble      = rsp.nibble;
   assign rsp_reg_select  = rsp.rs;
   assign rsp_wait_before = rsp.wait_before;
   assign rsp_wait_after  = rsp.wait_after;
   assign rsp_last        = rsp.last;

endmodule

FILE: design/lnw_front.sv
// request classifier: maps each request onto a queue entry
module lnw_front
   import lnw_pkg::*;
(
   input  logic [MODE_W-1:0] req_mode,
   input  logic [7:0]        req_value,
   input  logic              req_row,
   input  logic [5:0]        req_column,
   output lnw_entry_type     entry
);

   // choose sequence kind, byte and register select
   always_comb begin
      entry = '0;
      unique case (req_mode)
         MODE_INIT: begin
            entry.is_init = 1'b1;
            entry.rs      = RS_INSTR;
         end
         MODE_INSTR: begin
            entry.byte_val = req_value;
            entry.rs       = RS_INSTR;
         end
         MODE_DATA: begin
            entry.byte_val = req_value;
            entry.rs       = RS_DATA;
         end
         MODE_CURSOR: begin
            entry.byte_val = {2'b00, req_column} | (req_row ? ROW1_BASE : ROW0_BASE);
            entry.rs       = RS_INSTR;
         end
         default: entry = '0;
      endcase
   end

endmodule

FILE: design/lnw_queue.sv
// small request queue between classifier and sequencer
module lnw_queue
   import lnw_pkg::*;
#(
   parameter int unsigned QueueDepth = LNW_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lnw_entry_type push_entry,
   input  logic          pop,
   output lnw_entry_type head,
   output logic          empty,
   output logic          full
);

   localparam int unsigned PtrW = $clog2(QueueDepth);
   localparam int unsigned CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

   lnw_entry_type       slot_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CntW'(QueueDepth));
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update, pointers wrap at the last slot
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/lnw_back.sv
// nibble sequencer: walks the head entry one nibble write per cycle
module lnw_back
   import lnw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lnw_entry_type head,
   input  logic          empty,
   output logic          pop,
   output logic          rsp_valid,
   output lnw_rsp_type   rsp
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   lnw_rsp_type       rsp_ff, rsp_in;
   logic              final_step;

   assign final_step = head.is_init ? (step_ff == INIT_LAST_STEP)
                                    : (step_ff == BYTE_LAST_STEP);

   // next nibble write and step
   always_comb begin
      pop      = !empty && final_step;
      valid_in = !empty;
      rsp_in   = head.is_init ? init_rsp(step_ff)
                              : byte_rsp(head.byte_val, head.rs, step_ff[0]);
      step_in  = step_ff;
      if (!empty) begin
         step_in = final_step ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: design/lnw_checker.sv
// port-level checker of the lcd nibble writer, bound to the top level
`include "lcd_4bit_nibble_writer_defines.svh"

module lnw_checker
   import lnw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [3:0]          rsp_nibble,
   input logic                rsp_reg_select,
   input logic [WAIT_B_W-1:0] rsp_wait_before,
   input logic [WAIT_A_W-1:0] rsp_wait_after,
   input logic                rsp_last
);

   // only the first power-on nibble carries a lead-in wait
   `LNW_ASSERT_NOW(a_wait_before, clock, reset,
      rsp_valid && (rsp_wait_before != '0),
      (rsp_nibble == INIT_NIB_WAKE) && (rsp_reg_select == RS_INSTR),
      "lead-in wait on a nibble other than the first init nibble")

   // a request's nibble writes come out back to back
   `LNW_ASSERT_NEXT(a_no_gap, clock, reset,
      rsp_valid && !rsp_last, rsp_valid,
      "gap inside the nibble writes of one request")

   // a closing nibble always ends with a settle wait or the final init wait
   `LNW_ASSERT_NOW(a_last_settle, clock, reset,
      rsp_valid && rsp_last,
      (rsp_wait_after == WAIT_SETTLE) || (rsp_wait_after == WAIT_FINAL),
      "closing nibble without settle wait")

   // an accepted request produces output after passing the queue and the result register
   `LNW_ASSERT_NOW(a_latency, clock, reset,
      start && !busy, ##2 rsp_valid,
      "no result two cycles after an accepted request")

endmodule

bind lcd_4bit_nibble_writer lnw_checker u_lnw_checker (.*);
